// File: rtl/zse_pkg.sv
`timescale 1ns / 1ps

package zse_pkg;

    localparam int MAX_WORDS   = 4096;
    localparam int LANE        = 16;
    localparam int MASK_DEPTH  = (MAX_WORDS + LANE - 1) / LANE;
    localparam int DATA_AW     = $clog2(MAX_WORDS);
    localparam int MASK_AW     = $clog2(MASK_DEPTH);
    localparam int LANE_W      = $clog2(LANE);
    localparam int CNT_W       = DATA_AW + 1;
    localparam int NPAT_W      = MASK_AW + 1;
    localparam int WORD_W      = 16;
    localparam int CFG_W       = 13;
    localparam int PROD_W      = 2 * CFG_W;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    typedef enum logic
    {
        OP_PUSH = 1'b0,
        OP_PULL = 1'b1
    } opcode_t;

    typedef enum logic
    {
        REG_UNIT_COUNT = 1'b0,
        REG_UNIT_SIZE  = 1'b1
    } reg_index_t;

    // Block geometry handed from the register file to the datapath.
    typedef struct packed
    {
        logic [CNT_W-1:0]  size;
        logic [NPAT_W-1:0] npat;
    } geom_t;

endpackage

// File: rtl/zse_in_if.sv
`timescale 1ns / 1ps

interface zse_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [zse_pkg::WORD_W-1:0]  in_word;

    modport source (output valid, output opcode, output in_word, input ready);
    modport sink   (input valid, input opcode, input in_word, output ready);
endinterface

// File: rtl/zse_out_if.sv
`timescale 1ns / 1ps

interface zse_out_if;
    logic                        valid;
    logic                        ready;
    logic [zse_pkg::WORD_W-1:0]  out_word;
    logic                        out_valid;
    logic                        out_last;

    modport source (output valid, output out_word, output out_valid, output out_last,
                    input ready);
    modport sink   (input valid, input out_word, input out_valid, input out_last,
                    output ready);
endinterface

// File: rtl/zse_regs.sv
`timescale 1ns / 1ps

module zse_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [zse_pkg::APB_AW-1:0]   paddr,
    input  logic [zse_pkg::APB_DW-1:0]   pwdata,
    output logic [zse_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output zse_pkg::geom_t               geom
);

    logic [zse_pkg::CFG_W-1:0]  unit_count_reg;
    logic [zse_pkg::CFG_W-1:0]  unit_count_next;
    logic [zse_pkg::CFG_W-1:0]  unit_size_reg;
    logic [zse_pkg::CFG_W-1:0]  unit_size_next;
    logic [zse_pkg::PROD_W-1:0] prod;
    logic [zse_pkg::CNT_W-1:0]  size_reg;
    logic [zse_pkg::CNT_W-1:0]  size_next;
    logic                       wr_en;
    zse_pkg::reg_index_t        idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = zse_pkg::reg_index_t'(paddr[2]);

    always_comb
    begin
        case (idx)
            zse_pkg::REG_UNIT_COUNT: prdata = zse_pkg::APB_DW'(unit_count_reg);
            zse_pkg::REG_UNIT_SIZE:  prdata = zse_pkg::APB_DW'(unit_size_reg);
            default:                 prdata = '0;
        endcase
    end

    // The block size is computed from the values being written, so it changes
    // at the same edge as the register itself.
    always_comb
    begin
        unit_count_next = unit_count_reg;
        unit_size_next  = unit_size_reg;
        if (wr_en && idx == zse_pkg::REG_UNIT_COUNT)
        begin
            unit_count_next = pwdata[zse_pkg::CFG_W-1:0];
        end
        if (wr_en && idx == zse_pkg::REG_UNIT_SIZE)
        begin
            unit_size_next = pwdata[zse_pkg::CFG_W-1:0];
        end
        prod = unit_count_next * unit_size_next;
        if (prod > zse_pkg::PROD_W'(zse_pkg::MAX_WORDS))
        begin
            size_next = zse_pkg::CNT_W'(zse_pkg::MAX_WORDS);
        end
        else
        begin
            size_next = prod[zse_pkg::CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg <= '0;
            unit_size_reg  <= '0;
            size_reg       <= '0;
        end
        else
        begin
            unit_count_reg <= unit_count_next;
            unit_size_reg  <= unit_size_next;
            size_reg       <= size_next;
        end
    end

    assign geom.size = size_reg;
    assign geom.npat = zse_pkg::NPAT_W'((zse_pkg::CNT_W + 1)'(size_reg)
                       + (zse_pkg::CNT_W + 1)'(zse_pkg::LANE - 1) >> zse_pkg::LANE_W);

endmodule

// File: rtl/zero_suppress_expander.sv
`timescale 1ns / 1ps

// A pull's result is registered and appears on the output in the cycle after it is accepted.
// Throughput: one push or pull word per cycle while the output is not stalled; mask and data
// memories are read ahead at the next counter values, with write-first forwarding on a push.
// Reset: rst_n clears the counters and the output valid; the memories and result words need no clearing.
// A register write changes the block size at the same edge, so the next word sees it.
module zero_suppress_expander
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [zse_pkg::APB_AW-1:0]   paddr,
    input  logic [zse_pkg::APB_DW-1:0]   pwdata,
    output logic [zse_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    zse_in_if.sink                       in_ch,
    zse_out_if.source                    out_ch
);

    zse_pkg::geom_t geom;

    logic [zse_pkg::WORD_W-1:0] mask_mem [zse_pkg::MASK_DEPTH];
    logic [zse_pkg::WORD_W-1:0] data_mem [zse_pkg::MAX_WORDS];

    logic [zse_pkg::CNT_W-1:0]   wr_cnt_reg, wr_cnt_next;
    logic [zse_pkg::CNT_W-1:0]   pos_reg, pos_next;
    logic [zse_pkg::CNT_W-1:0]   dri_reg, dri_next;
    logic [zse_pkg::WORD_W-1:0]  mask_rd_reg, data_rd_reg;
    logic                        res_valid_reg, res_valid_next;
    logic [zse_pkg::WORD_W-1:0]  res_word_reg, res_word_next;
    logic                        res_ok_reg, res_ok_next;
    logic                        res_last_reg, res_last_next;

    logic                        accept;
    logic                        mask_we, data_we;
    logic [zse_pkg::MASK_AW-1:0] mask_waddr, mask_raddr;
    logic [zse_pkg::DATA_AW-1:0] data_waddr, data_raddr;
    logic [zse_pkg::CNT_W-1:0]   data_off;
    logic [zse_pkg::CNT_W:0]     data_need;
    logic [zse_pkg::CNT_W-1:0]   pos_inc;

    zse_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom)
    );

    assign in_ch.ready = !res_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    assign data_off   = wr_cnt_reg - zse_pkg::CNT_W'(geom.npat);
    assign mask_waddr = wr_cnt_reg[zse_pkg::MASK_AW-1:0];
    assign data_waddr = data_off[zse_pkg::DATA_AW-1:0];
    assign data_need  = (zse_pkg::CNT_W + 1)'(geom.npat) + (zse_pkg::CNT_W + 1)'(dri_reg);
    assign pos_inc    = pos_reg + zse_pkg::CNT_W'(1);

    always_comb
    begin
        wr_cnt_next    = wr_cnt_reg;
        pos_next       = pos_reg;
        dri_next       = dri_reg;
        mask_we        = 1'b0;
        data_we        = 1'b0;
        res_valid_next = res_valid_reg && !out_ch.ready;
        res_word_next  = res_word_reg;
        res_ok_next    = res_ok_reg;
        res_last_next  = res_last_reg;

        if (accept)
        begin
            case (zse_pkg::opcode_t'(in_ch.opcode))
                zse_pkg::OP_PUSH:
                begin
                    if (wr_cnt_reg < zse_pkg::CNT_W'(geom.npat))
                    begin
                        mask_we     = 1'b1;
                        wr_cnt_next = wr_cnt_reg + zse_pkg::CNT_W'(1);
                    end
                    else if (data_off < geom.size)
                    begin
                        data_we     = 1'b1;
                        wr_cnt_next = wr_cnt_reg + zse_pkg::CNT_W'(1);
                    end
                end
                zse_pkg::OP_PULL:
                begin
                    res_valid_next = 1'b1;
                    res_word_next  = '0;
                    res_ok_next    = 1'b0;
                    res_last_next  = 1'b0;
                    if (geom.size == '0)
                    begin
                        res_ok_next = 1'b0;
                    end
                    else if (pos_reg >= geom.size)
                    begin
                        wr_cnt_next = '0;
                        pos_next    = '0;
                        dri_next    = '0;
                    end
                    else if (wr_cnt_reg > (pos_reg >> zse_pkg::LANE_W))
                    begin
                        if (!mask_rd_reg[pos_reg[zse_pkg::LANE_W-1:0]])
                        begin
                            res_ok_next = 1'b1;
                            pos_next    = pos_inc;
                        end
                        else if (dri_reg < geom.size
                                 && (zse_pkg::CNT_W + 1)'(wr_cnt_reg) > data_need)
                        begin
                            res_ok_next   = 1'b1;
                            res_word_next = data_rd_reg;
                            pos_next      = pos_inc;
                            dri_next      = dri_reg + zse_pkg::CNT_W'(1);
                        end
                        if (res_ok_next && pos_inc >= geom.size)
                        begin
                            res_last_next = 1'b1;
                            wr_cnt_next   = '0;
                            pos_next      = '0;
                            dri_next      = '0;
                        end
                    end
                end
                default:
                begin
                    res_valid_next = res_valid_reg && !out_ch.ready;
                end
            endcase
        end
    end

    // Reads are issued at the next counter values so the data is ready for the next pull.
    assign mask_raddr = pos_next[zse_pkg::DATA_AW-1:zse_pkg::LANE_W];
    assign data_raddr = dri_next[zse_pkg::DATA_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mask_we)
        begin
            mask_mem[mask_waddr] <= in_ch.in_word;
        end
        if (mask_we && mask_waddr == mask_raddr)
        begin
            mask_rd_reg <= in_ch.in_word;
        end
        else
        begin
            mask_rd_reg <= mask_mem[mask_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (data_we)
        begin
            data_mem[data_waddr] <= in_ch.in_word;
        end
        if (data_we && data_waddr == data_raddr)
        begin
            data_rd_reg <= in_ch.in_word;
        end
        else
        begin
            data_rd_reg <= data_mem[data_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_cnt_reg    <= '0;
            pos_reg       <= '0;
            dri_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            wr_cnt_reg    <= wr_cnt_next;
            pos_reg       <= pos_next;
            dri_reg       <= dri_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_word_reg <= res_word_next;
        res_ok_reg   <= res_ok_next;
        res_last_reg <= res_last_next;
    end

    assign out_ch.valid     = res_valid_reg;
    assign out_ch.out_word  = res_word_reg;
    assign out_ch.out_valid = res_ok_reg;
    assign out_ch.out_last  = res_last_reg;

endmodule

// File: tb/sv/tb_zero_suppress_expander.sv
`timescale 1ns / 1ps

module tb_zero_suppress_expander;

    typedef struct packed
    {
        logic [zse_pkg::WORD_W-1:0] out_word;
        logic                       out_valid;
        logic                       out_last;
    } expanded_t;

    // Tracks the expander's block state and the expanded words still owed.
    class expansion_tracker;
        logic [zse_pkg::WORD_W-1:0] mask_mem [zse_pkg::MASK_DEPTH];
        logic [zse_pkg::WORD_W-1:0] data_mem [zse_pkg::MAX_WORDS];
        int unsigned       unit_count;
        int unsigned       unit_size;
        int unsigned       rcvd;
        int unsigned       opos;
        int unsigned       rd_idx;
        int unsigned       blocks_done;
        int unsigned       failures;
        expanded_t         expected_words [$];

        function int unsigned block_words();
            int unsigned prod;
            prod = unit_count * unit_size;
            return (prod > zse_pkg::MAX_WORDS) ? zse_pkg::MAX_WORDS : prod;
        endfunction

        function void set_reg(zse_pkg::reg_index_t idx, int unsigned value);
            if (idx == zse_pkg::REG_UNIT_COUNT)
                unit_count = value & 32'h1fff;
            else
                unit_size = value & 32'h1fff;
        endfunction

        function void restart();
            rcvd   = 0;
            opos   = 0;
            rd_idx = 0;
        endfunction

        function void note_input(zse_pkg::opcode_t op, logic [zse_pkg::WORD_W-1:0] w);
            int unsigned sz;
            int unsigned npat;
            int unsigned pos;
            bit          advance;
            expanded_t   r;
            sz   = block_words();
            npat = (sz + zse_pkg::LANE - 1) / zse_pkg::LANE;
            if (op == zse_pkg::OP_PUSH)
            begin
                if (rcvd < npat)
                begin
                    mask_mem[rcvd] = w;
                    rcvd++;
                end
                else if (rcvd - npat < sz)
                begin
                    data_mem[rcvd - npat] = w;
                    rcvd++;
                end
                return;
            end
            r = '0;
            pos = opos;
            advance = 1'b0;
            if (sz != 0)
            begin
                // A size shrunk below the current position closes the block.
                if (pos >= sz)
                    restart();
                else if (rcvd > pos / zse_pkg::LANE)
                begin
                    if (mask_mem[pos / zse_pkg::LANE][pos % zse_pkg::LANE])
                    begin
                        if (rd_idx < sz && rcvd > npat + rd_idx)
                        begin
                            r.out_word = data_mem[rd_idx];
                            rd_idx++;
                            advance = 1'b1;
                        end
                    end
                    else
                        advance = 1'b1;
                    if (advance)
                    begin
                        opos = pos + 1;
                        r.out_valid = 1'b1;
                        if (opos >= sz)
                        begin
                            r.out_last = 1'b1;
                            restart();
                            blocks_done++;
                        end
                    end
                end
            end
            expected_words.push_back(r);
        endfunction

        function void check_word(logic [zse_pkg::WORD_W-1:0] w, logic v, logic l);
            expanded_t e;
            if (expected_words.size() == 0)
            begin
                $error("output word %h with no pull waiting", w);
                failures++;
                return;
            end
            e = expected_words.pop_front();
            if (w !== e.out_word)
            begin
                $error("out_word: expected %h, got %h", e.out_word, w);
                failures++;
            end
            if (v !== e.out_valid)
            begin
                $error("out_valid: expected %b, got %b", e.out_valid, v);
                failures++;
            end
            if (l !== e.out_last)
            begin
                $error("out_last: expected %b, got %b", e.out_last, l);
                failures++;
            end
        endfunction
    endclass

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [zse_pkg::APB_AW-1:0] paddr = '0;
    logic [zse_pkg::APB_DW-1:0] pwdata = '0;
    logic [zse_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    bit                         quiet = 1'b0;
    int unsigned                stall_left = 0;
    int unsigned                item_total = 0;
    expansion_tracker           tracker = new;

    zse_in_if  in_ch ();
    zse_out_if out_ch ();

    zero_suppress_expander uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (in_ch),
        .out_ch  (out_ch)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid   = 1'b0;
        in_ch.opcode  = zse_pkg::OP_PUSH;
        in_ch.in_word = '0;
        out_ch.ready  = 1'b0;
    end

    // Receiver back-pressure in bursts; none in the closing stretch.
    always @(negedge clk)
    begin
        if (quiet)
            out_ch.ready <= 1'b1;
        else if (stall_left != 0)
        begin
            out_ch.ready <= 1'b0;
            stall_left = stall_left - 1;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left = $urandom_range(1, 17) - 1;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            tracker.check_word(out_ch.out_word, out_ch.out_valid, out_ch.out_last);
    end

    task automatic send_item(input zse_pkg::opcode_t op,
                             input logic [zse_pkg::WORD_W-1:0] w);
        int unsigned gap;
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.in_word <= w;
        do @(posedge clk); while (!in_ch.ready);
        tracker.note_input(op, w);
    endtask

    // Stops sending and waits until every pull has produced its word.
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (tracker.expected_words.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input zse_pkg::reg_index_t idx, input int unsigned value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        tracker.set_reg(idx, value);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== zse_pkg::APB_DW'(value))
        begin
            $error("%s readback: expected %0d, got %0d", idx.name(), value, prdata);
            tracker.failures++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_geometry(input int unsigned count, input int unsigned size);
        drain();
        apb_write(zse_pkg::REG_UNIT_COUNT, count);
        apb_write(zse_pkg::REG_UNIT_SIZE, size);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [zse_pkg::WORD_W-1:0] data_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return zse_pkg::WORD_W'($urandom);
        endcase
    endfunction

    task automatic pick_geometry(output int unsigned count, output int unsigned size);
        case ($urandom_range(0, 9))
            0:
            begin
                count = $urandom_range(1, 4);
                size  = $urandom_range(1, 4);
            end
            6:
            begin
                count = 1;
                size  = $urandom_range(1, 200);
            end
            7:
            begin
                count = $urandom_range(1, 300);
                size  = 1;
            end
            8:
            begin
                count = $urandom_range(0, 1) ? 0 : $urandom_range(1, 4096);
                size  = (count == 0) ? $urandom_range(0, 4096) : 0;
            end
            9:
            begin
                count = 16;
                size  = 16;
            end
            default:
            begin
                count = $urandom_range(1, 8);
                size  = $urandom_range(1, 16);
            end
        endcase
    endtask

    // One well-formed block: mask words, then the data words they call for, with
    // pulls mixed in early and a few surplus words now and then; an empty block gets three random items.
    task automatic run_block();
        int unsigned                sz;
        int unsigned                npat;
        int unsigned                ndata;
        int unsigned                mode;
        int unsigned                done_mark;
        int unsigned                k;
        int unsigned                b;
        logic [zse_pkg::WORD_W-1:0] m;
        logic [zse_pkg::WORD_W-1:0] stream [$];
        sz = tracker.block_words();
        if (sz == 0)
        begin
            repeat (3)
            begin
                send_item(zse_pkg::opcode_t'($urandom_range(0, 1)),
                          zse_pkg::WORD_W'($urandom));
                item_total++;
            end
            return;
        end
        npat  = (sz + zse_pkg::LANE - 1) / zse_pkg::LANE;
        mode  = $urandom_range(0, 3);
        ndata = 0;
        for (k = 0; k < npat; k++)
        begin
            case (mode)
                0:       m = '0;
                1:       m = '1;
                2:       m = zse_pkg::WORD_W'($urandom);
                default: m = zse_pkg::WORD_W'($urandom & $urandom & $urandom);
            endcase
            stream.push_back(m);
            for (b = 0; b < zse_pkg::LANE; b++)
                if (k * zse_pkg::LANE + b < sz && m[b])
                    ndata++;
        end
        for (k = 0; k < ndata; k++)
            stream.push_back(data_value());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) stream.push_back(zse_pkg::WORD_W'($urandom));
        done_mark = tracker.blocks_done;
        while (tracker.blocks_done == done_mark)
        begin
            if (stream.size() != 0 && $urandom_range(0, 3) != 0)
                send_item(zse_pkg::OP_PUSH, stream.pop_front());
            else
                send_item(zse_pkg::OP_PULL, zse_pkg::WORD_W'($urandom));
            item_total++;
        end
    endtask

    initial
    begin
        int unsigned count;
        int unsigned size;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty block: pulls give nothing and pushes are dropped.
        send_item(zse_pkg::OP_PULL, '1);
        send_item(zse_pkg::OP_PUSH, 16'hffff);
        send_item(zse_pkg::OP_PULL, '0);
        set_geometry(4096, 0);
        send_item(zse_pkg::OP_PULL, '0);
        set_geometry(0, 4096);
        send_item(zse_pkg::OP_PULL, '1);

        // Pulls ahead of their mask or data word are refused.
        set_geometry(2, 16);
        send_item(zse_pkg::OP_PULL, '0);
        send_item(zse_pkg::OP_PUSH, 16'h8001);
        send_item(zse_pkg::OP_PULL, '0);
        send_item(zse_pkg::OP_PUSH, 16'h0000);
        send_item(zse_pkg::OP_PUSH, 16'hffff);
        send_item(zse_pkg::OP_PULL, '1);
        send_item(zse_pkg::OP_PULL, '0);
        send_item(zse_pkg::OP_PULL, '0);

        // Shrinking the block below the current position closes it on the next pull.
        set_geometry(1, 1);
        send_item(zse_pkg::OP_PULL, '0);
        send_item(zse_pkg::OP_PUSH, 16'h0000);
        send_item(zse_pkg::OP_PUSH, 16'h1234);
        send_item(zse_pkg::OP_PUSH, 16'h5555);
        send_item(zse_pkg::OP_PULL, '0);
        send_item(zse_pkg::OP_PULL, '0);

        // Product far beyond the store clamps to the full depth; the first mask
        // word covers sixteen positions and the next pull waits for another one.
        set_geometry(4096, 4096);
        send_item(zse_pkg::OP_PUSH, 16'h0000);
        repeat (17) send_item(zse_pkg::OP_PULL, '0);
        set_geometry(1, 1);
        send_item(zse_pkg::OP_PULL, '0);

        item_total = 0;
        while (item_total < 1950)
        begin
            if ($urandom_range(0, 1) == 0)
            begin
                pick_geometry(count, size);
                set_geometry(count, size);
            end
            else if ($urandom_range(0, 7) == 0)
                drain();
            if (item_total >= 1700)
                quiet = 1'b1;
            run_block();
        end

        drain();
        repeat (8) @(posedge clk);
        if (tracker.failures == 0)
            $display("zero_suppress_expander: match");
        else
            $display("zero_suppress_expander: mismatch");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("zero_suppress_expander: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/zse_pkg.sv
rtl/zse_in_if.sv
rtl/zse_out_if.sv
rtl/zse_regs.sv
rtl/zero_suppress_expander.sv
tb/sv/tb_zero_suppress_expander.sv
